// ===== src/pbpc_pkg.sv =====
// Package with the shared types, constants and functions of the PCG32 block pattern checker.
package pbpc_pkg;

    localparam int DATA_W  = 32;
    localparam int INDEX_W = 32;
    localparam int NVAL_W  = 3;
    localparam int KEY_W   = 40;
    localparam int STATE_W = 64;
    localparam int HALF_W  = 32;

    // Padded stream widths: input holds index, data and byte count; output holds flags and word.
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;

    localparam logic [KEY_W-1:0]   KEY_RESET   = 40'hD1_5CDA_7A00;
    localparam logic [STATE_W-1:0] LCG_INC     = 64'h1405_7B7E_F767_814F;
    localparam logic [HALF_W-1:0]  LCG_MUL_LO  = 32'h4C95_7F2D;
    localparam logic [HALF_W-1:0]  LCG_MUL_HI  = 32'h5851_F42D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_A,
        ST_SEED_B,
        ST_STEP_A,
        ST_STEP_B
    } pbpc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;   // capture the accepted transaction (and seed on a start word)
        logic mul_lo;    // first half of the LCG step: low and first cross product
        logic mul_hi;    // second half: second cross product, sum, state update
        logic emit;      // write the result register and update the block verdict
    } pbpc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // result register is empty or being taken this cycle
    } pbpc_status_t;

    // XSH-RR output permutation of the 64-bit generator state.
    function automatic logic [DATA_W-1:0] pcg_permute(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] mix;
        logic [DATA_W-1:0]  x;
        logic [4:0]         r;
        mix = s ^ (s >> 18);
        x   = mix[58:27];
        r   = s[63:59];
        return (x >> r) | (x << ((6'd32 - {1'b0, r}) & 6'd31));
    endfunction

    // Byte mask over the valid low bytes; four or more compares the whole word.
    function automatic logic [DATA_W-1:0] byte_mask(input logic [NVAL_W-1:0] n);
        logic [DATA_W-1:0] m;
        case (n)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// ===== src/pbpc_ctrl.sv =====
// Controller state machine that sequences seeding, comparison and LCG steps.
module pbpc_ctrl
    import pbpc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tuser,
    output logic         s_tready,
    input  pbpc_status_t status,
    output pbpc_cmd_t    cmd
);

    pbpc_state_t state_reg, state_next;
    logic        in_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        in_fire     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                in_fire     = s_tvalid;
                cmd.load_in = in_fire;
                if (in_fire) begin
                    state_next = s_tuser ? ST_SEED_A : ST_STEP_A;
                end
            end
            ST_SEED_A: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_SEED_B;
            end
            ST_SEED_B: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_STEP_A;
            end
            ST_STEP_A: begin
                // The expected word comes from the state before this step advances it.
                cmd.mul_lo = 1'b1;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_STEP_B;
                end
            end
            ST_STEP_B: begin
                cmd.mul_hi  = 1'b1;
                s_tready    = 1'b1;
                in_fire     = s_tvalid;
                cmd.load_in = in_fire;
                if (in_fire) begin
                    state_next = s_tuser ? ST_SEED_A : ST_STEP_A;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/pbpc_datapath.sv =====
// Datapath with the generator state, split LCG multiplier, comparator and result register.
module pbpc_datapath
    import pbpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pbpc_cmd_t            cmd,
    output pbpc_status_t         status,
    input  logic [KEY_W-1:0]     key_offset,
    input  logic                 in_start,
    input  logic [INDEX_W-1:0]   in_block_index,
    input  logic [DATA_W-1:0]    in_data_word,
    input  logic [NVAL_W-1:0]    in_valid_bytes,
    input  logic                 in_last,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic [STATE_W-1:0] lcg_state_reg, lcg_state_next;
    logic [STATE_W-1:0] lo_prod_reg;
    logic [HALF_W-1:0]  cross_reg;
    logic               block_good_reg;
    logic [DATA_W-1:0]  data_reg;
    logic [NVAL_W-1:0]  nvalid_reg;
    logic               last_reg;
    logic               m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic               m_last_reg;

    logic [STATE_W-1:0] seed_c;
    logic [HALF_W-1:0]  s_lo, s_hi;
    logic [STATE_W-1:0] lo_prod_c;
    logic [HALF_W-1:0]  cross_a_c, cross_b_c, hi_sum_c;
    logic [DATA_W-1:0]  expect_c;
    logic               word_ok_c, block_ok_c;

    assign s_lo = lcg_state_reg[HALF_W-1:0];
    assign s_hi = lcg_state_reg[STATE_W-1:HALF_W];

    assign seed_c = LCG_INC + {{(STATE_W-KEY_W){1'b0}}, key_offset}
                  + {{(STATE_W-INDEX_W){1'b0}}, in_block_index};

    // The 64x64 product modulo 2^64 is built from three 32x32 products, split over the mul_lo and mul_hi steps.
    assign lo_prod_c = {{HALF_W{1'b0}}, s_lo} * {{HALF_W{1'b0}}, LCG_MUL_LO};
    assign cross_a_c = s_lo * LCG_MUL_HI;
    assign cross_b_c = s_hi * LCG_MUL_LO;
    assign hi_sum_c  = lo_prod_reg[STATE_W-1:HALF_W] + cross_reg + cross_b_c;
    assign lcg_state_next = {hi_sum_c, lo_prod_reg[HALF_W-1:0]} + LCG_INC;

    assign expect_c   = pcg_permute(lcg_state_reg);
    assign word_ok_c  = ((data_reg ^ expect_c) & byte_mask(nvalid_reg)) == '0;
    assign block_ok_c = block_good_reg & word_ok_c;

    assign status.out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcg_state_reg  <= '0;
            block_good_reg <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.load_in && in_start) begin
                lcg_state_reg  <= seed_c;
                block_good_reg <= 1'b1;
            end else if (cmd.mul_hi) begin
                lcg_state_reg <= lcg_state_next;
            end
            if (cmd.emit) begin
                block_good_reg <= block_ok_c;
                m_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            data_reg   <= in_data_word;
            nvalid_reg <= in_valid_bytes;
            last_reg   <= in_last;
        end
        if (cmd.mul_lo) begin
            lo_prod_reg <= lo_prod_c;
            cross_reg   <= cross_a_c;
        end
        if (cmd.emit) begin
            m_data_reg <= {{(M_TDATA_W-DATA_W-2){1'b0}}, expect_c, block_ok_c, word_ok_c};
            m_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== src/pcg32_block_pattern_checker.sv =====
// Top level of the PCG32 block pattern checker: key register, controller and datapath.
//
//   channel  direction  handshake             contents
//   s_       in         s_tvalid / s_tready   tuser start_req, tdata index/data/bytes, tlast
//   m_       out        m_tvalid / m_tready   tdata word_ok/block_ok/expected_word, tlast
//   cfg_     in         cfg_valid / cfg_ready key_offset (40 bits)
//
// A word without a start runs through ST_STEP_A and ST_STEP_B, and a start word runs through
// ST_SEED_A and ST_SEED_B first: each LCG step is split over the mul_lo and mul_hi halves of a
// split 32x32 multiplier. The next transaction is taken in ST_STEP_B of the current word's step.
// The result register holds one finished word; the block waits before emitting while it is full.
// Reset (aresetn low, synchronous) clears the generator state to 0 and the verdict to 1.
module pcg32_block_pattern_checker
    import pbpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] block_index, [63:32] data_word,
                                            // [66:64] valid_bytes, [71:67] zero
    input  logic                 s_tuser,   // [0] start_req
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [0] word_ok, [1] block_ok,
                                            // [33:2] expected_word, [39:34] zero
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [KEY_W-1:0]     cfg_data
);

    logic [KEY_W-1:0] key_offset_reg;
    pbpc_cmd_t        cmd;
    pbpc_status_t     status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_offset_reg <= KEY_RESET;
        end else if (cfg_valid) begin
            key_offset_reg <= cfg_data;
        end
    end

    pbpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pbpc_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .key_offset     (key_offset_reg),
        .in_start       (s_tuser),
        .in_block_index (s_tdata[31:0]),
        .in_data_word   (s_tdata[63:32]),
        .in_valid_bytes (s_tdata[66:64]),
        .in_last        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast)
    );

endmodule
